// File: design/prr_pkg.sv
// Shared types and constants for the polyphase rational resampler.
`timescale 1ns / 1ps
package prr_pkg;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_FROM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAPS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO = 3'd5;
  localparam int unsigned RESULTS_MAX = 16;
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic acc_en;
  } mac_ctrl_t;
endpackage

// File: design/prr_mac.sv
// Shared multiply-accumulate unit for both channels, with rounding and saturation.
`timescale 1ns / 1ps
module prr_mac #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned ACC_W = 48
) (
  input  logic                          clk,
  input  prr_pkg::mac_ctrl_t            ctrl,
  input  logic signed [15:0]            coef,
  input  logic signed [SAMPLE_BITS-1:0] hist_l,
  input  logic signed [SAMPLE_BITS-1:0] hist_r,
  output logic signed [SAMPLE_BITS-1:0] res_l,
  output logic signed [SAMPLE_BITS-1:0] res_r
);
  import prr_pkg::*;

  localparam int unsigned SH_W = ACC_W - 15;

  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;
  logic signed [ACC_W-1:0] prod_l, prod_r;
  logic signed [SAMPLE_BITS+15:0] mul_l, mul_r;

  // Full-width signed products, sign-extended into the accumulator width.
  assign mul_l = coef * hist_l;
  assign mul_r = coef * hist_r;
  assign prod_l = ACC_W'(mul_l);
  assign prod_r = ACC_W'(mul_r);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_l_r <= acc_l_r + prod_l;
      acc_r_r <= acc_r_r + prod_r;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] b;
    logic signed [SH_W-1:0] s;
    logic signed [SH_W-1:0] mx;
    logic signed [SH_W-1:0] mn;
    b  = a + ACC_W'(1 << 14);
    s  = SH_W'(b >>> 15);
    mx = SH_W'((1 << (SAMPLE_BITS - 1)) - 1);
    mn = -mx - SH_W'(1);
    if (s > mx) rnd_sat = mx[SAMPLE_BITS-1:0];
    else if (s < mn) rnd_sat = mn[SAMPLE_BITS-1:0];
    else rnd_sat = s[SAMPLE_BITS-1:0];
  endfunction

  assign res_l = rnd_sat(acc_l_r);
  assign res_r = rnd_sat(acc_r_r);
endmodule

// File: design/polyphase_rational_resampler.sv
// Top level of the polyphase rational resampler: sequencer, stores and stream ports.
`timescale 1ns / 1ps
// Rational resampler for mono or stereo audio with a loaded polyphase FIR. A coefficient
// write is stored while the sequencer stays idle, and a pass-through sample (from_factor
// equal to to_factor) gives one output. Any other sample item produces up to 16 outputs.
// For each output the phase is found by two passes of one shared shift-subtract divider,
// then the taps run through one shared multiply-accumulate unit for both channels (one
// coefficient and one history read per cycle), followed by check, drain and hand-over.
// The input is not ready while a sample item is in progress, also while a result waits
// for out_tready. The coefficient store is undefined until written; the history reads as
// zero after reset through valid bits.
module polyphase_rational_resampler #(
  parameter int unsigned TAPS_MAX = 128,
  parameter int unsigned COEF_DEPTH = 1024,
  parameter int unsigned BLOCK_MAX = 1024,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [prr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // coef_index, coef_value, sample_left, sample_right (from bit 0 up)
  input  logic [63:0]                        in_tdata,
  // operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_left, out_right (from bit 0 up)
  output logic [2*SAMPLE_BITS-1:0]           out_tdata,
  output logic                               out_tlast
);
  import prr_pkg::*;

  localparam int unsigned HP_W = $clog2(TAPS_MAX);
  localparam int unsigned CA_W = $clog2(COEF_DEPTH);
  localparam int unsigned BK_W = $clog2(BLOCK_MAX + 1);
  localparam int unsigned OJ_W = BK_W + 5;
  localparam int unsigned DV_W = OJ_W + 5;
  localparam int unsigned TP_W = $clog2(TAPS_MAX + 1);
  localparam int unsigned CI_W = 5 + 4 + TP_W + 5;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_MAC = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;
  localparam logic [2:0] ST_PASS = 3'd6;
  localparam logic [2:0] ST_DIV = 3'd7;

  // Configuration registers.
  logic [4:0] from_r, to_r, pcnt_r;
  logic [7:0] taps_cfg_r;
  logic [10:0] blk_cfg_r;
  logic stereo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_r <= 5'd1;
      to_r <= 5'd1;
      pcnt_r <= 5'd1;
      taps_cfg_r <= 8'd1;
      blk_cfg_r <= 11'd128;
      stereo_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FROM:   from_r <= cfg_data[4:0];
        REG_TO:     to_r <= cfg_data[4:0];
        REG_PHASE:  pcnt_r <= cfg_data[4:0];
        REG_TAPS:   taps_cfg_r <= cfg_data[7:0];
        REG_BLOCK:  blk_cfg_r <= cfg_data[10:0];
        REG_STEREO: stereo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [4:0] fr, to_f, pc;
  logic [TP_W-1:0] taps;
  logic [BK_W-1:0] blk;
  assign fr = (from_r == 5'd0) ? 5'd1 : from_r;
  assign to_f = (to_r == 5'd0) ? 5'd1 : to_r;
  assign pc = (pcnt_r == 5'd0) ? 5'd1 : pcnt_r;
  always_comb begin
    if (taps_cfg_r == 8'd0) taps = TP_W'(1);
    else if (32'(taps_cfg_r) > TAPS_MAX) taps = TP_W'(TAPS_MAX);
    else taps = TP_W'(taps_cfg_r);
    if (blk_cfg_r == 11'd0) blk = BK_W'(1);
    else if (32'(blk_cfg_r) > BLOCK_MAX) blk = BK_W'(BLOCK_MAX);
    else blk = BK_W'(blk_cfg_r);
  end

  // Input fields.
  logic [9:0] in_cidx;
  logic signed [15:0] in_cval;
  logic signed [15:0] in_sl, in_sr;
  assign in_cidx = in_tdata[9:0];
  assign in_cval = in_tdata[25:10];
  assign in_sl = in_tdata[41:26];
  assign in_sr = in_tdata[57:42];

  // State.
  logic [2:0] st_r;
  logic [HP_W-1:0] hptr_r;
  logic [BK_W-1:0] kin_r;
  logic [OJ_W-1:0] jout_r;
  logic [4:0] nres_r;
  logic [TP_W-1:0] tap_r;
  logic [CI_W-1:0] cidx_r;
  logic signed [SAMPLE_BITS-1:0] sl_r, sr_r;
  logic [TAPS_MAX-1:0] hvalid_r;
  // Shift-subtract divider by to_factor: first (j*fr) mod to, then (that*pc) / to.
  logic [DV_W-1:0] dv_r;
  logic [3:0] rm_r;
  logic [4:0] dcnt_r;
  logic dpass_r;
  logic mac_pipe_r;
  logic [1:0] drain_r;
  logic out_valid_r, out_last_r;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_r_r;

  // Memories.
  logic signed [15:0] coef_mem [COEF_DEPTH];
  logic signed [SAMPLE_BITS-1:0] hist_l_mem [TAPS_MAX];
  logic signed [SAMPLE_BITS-1:0] hist_r_mem [TAPS_MAX];
  logic signed [15:0] coef_rd_r;
  logic signed [SAMPLE_BITS-1:0] hl_rd_r, hr_rd_r;
  logic hv_rd_r, cv_rd_r;

  logic in_acc, out_acc, out_free, out_load;
  assign in_tready = (st_r == ST_IDLE) && rst_n;
  assign in_acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign out_free = !out_valid_r || out_acc;
  assign out_load = out_free && (st_r == ST_PASS || st_r == ST_EMIT);

  logic [HP_W-1:0] hrd_addr;
  assign hrd_addr = hptr_r - HP_W'(1) - tap_r[HP_W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_COEF && 32'(in_cidx) < COEF_DEPTH)
      coef_mem[in_cidx[CA_W-1:0]] <= in_cval;
    coef_rd_r <= coef_mem[cidx_r[CA_W-1:0]];
    cv_rd_r <= 32'(cidx_r) < COEF_DEPTH;
    hl_rd_r <= hist_l_mem[hrd_addr];
    hr_rd_r <= hist_r_mem[hrd_addr];
    hv_rd_r <= hvalid_r[hrd_addr];
    if (st_r == ST_PUSH) begin
      hist_l_mem[hptr_r] <= sl_r;
      hist_r_mem[hptr_r] <= sr_r;
    end
  end

  mac_ctrl_t mac_ctrl;
  logic signed [15:0] mac_coef;
  logic signed [SAMPLE_BITS-1:0] mac_hl, mac_hr, res_l, res_r;
  assign mac_ctrl.clear = (st_r == ST_CHECK);
  assign mac_ctrl.acc_en = mac_pipe_r;
  assign mac_coef = cv_rd_r ? coef_rd_r : 16'sd0;
  assign mac_hl = hv_rd_r ? hl_rd_r : '0;
  assign mac_hr = hv_rd_r ? hr_rd_r : '0;

  prr_mac #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_W(SAMPLE_BITS + 16 + 11)) u_mac (
    .clk(clk), .ctrl(mac_ctrl), .coef(mac_coef), .hist_l(mac_hl), .hist_r(mac_hr),
    .res_l(res_l), .res_r(res_r)
  );

  // Output j is due while j < floor(blk*to/fr), i.e. (j+1)*fr <= blk*to, and j*fr < (k+1)*to.
  logic [DV_W-1:0] due_lhs, due_rhs, nxt_lhs, lim_prod;
  assign due_lhs = DV_W'(jout_r) * DV_W'(fr);
  assign nxt_lhs = DV_W'(jout_r + OJ_W'(1)) * DV_W'(fr);
  assign due_rhs = DV_W'(kin_r + BK_W'(1)) * DV_W'(to_f);
  assign lim_prod = DV_W'(blk) * DV_W'(to_f);
  logic due_now, more_due;
  assign due_now = (32'(nres_r) < RESULTS_MAX) && (due_lhs + DV_W'(fr) <= lim_prod)
                   && (due_lhs < due_rhs);
  assign more_due = (32'(nres_r) < RESULTS_MAX - 1) && (nxt_lhs + DV_W'(fr) <= lim_prod)
                    && (nxt_lhs < due_rhs);

  logic [4:0] rm_sh;
  logic rm_ge;
  logic [3:0] rm_step;
  logic [DV_W-1:0] dv_step;
  logic [8:0] phase_num;
  assign rm_sh = {rm_r, dv_r[DV_W-1]};
  assign rm_ge = rm_sh >= to_f;
  assign rm_step = rm_ge ? 4'(rm_sh - to_f) : rm_sh[3:0];
  assign dv_step = {dv_r[DV_W-2:0], rm_ge};
  assign phase_num = 9'(rm_step) * 9'(pc);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_acc) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      hptr_r <= '0;
      kin_r <= '0;
      jout_r <= '0;
      hvalid_r <= '0;
      mac_pipe_r <= 1'b0;
    end else begin
      mac_pipe_r <= (st_r == ST_MAC);
      case (st_r)
        ST_IDLE: begin
          if (in_acc && in_tuser == OP_SAMPLE) begin
            sl_r <= in_sl;
            sr_r <= in_sr;
            nres_r <= '0;
            if (fr == to_f) st_r <= ST_PASS;
            else st_r <= ST_CHECK;
          end
        end
        ST_PASS: begin
          if (out_free) begin
            out_l_r <= sl_r;
            out_r_r <= stereo_r ? sr_r : '0;
            out_last_r <= 1'b1;
            st_r <= ST_IDLE;
          end
        end
        ST_CHECK: begin
          if (due_now) begin
            dv_r <= due_lhs;
            rm_r <= '0;
            dcnt_r <= 5'(DV_W);
            dpass_r <= 1'b0;
            st_r <= ST_DIV;
          end else st_r <= ST_PUSH;
        end
        ST_DIV: begin
          // The phase is floor(((j*fr) mod to) * pc / to).
          if (dcnt_r != 5'd1) begin
            dv_r <= dv_step;
            rm_r <= rm_step;
            dcnt_r <= dcnt_r - 5'd1;
          end else if (!dpass_r) begin
            dv_r <= {phase_num, {(DV_W-9){1'b0}}};
            rm_r <= '0;
            dcnt_r <= 5'd9;
            dpass_r <= 1'b1;
          end else begin
            cidx_r <= CI_W'(dv_step[3:0]);
            tap_r <= '0;
            st_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          tap_r <= tap_r + TP_W'(1);
          cidx_r <= cidx_r + CI_W'(pc);
          if (tap_r + TP_W'(1) == taps) begin
            st_r <= ST_DRAIN;
            drain_r <= 2'd0;
          end
        end
        ST_DRAIN: begin
          drain_r <= drain_r + 2'd1;
          if (drain_r == 2'd1) st_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_l_r <= res_l;
            out_r_r <= stereo_r ? res_r : '0;
            out_last_r <= !more_due;
            nres_r <= nres_r + 5'd1;
            jout_r <= jout_r + OJ_W'(1);
            st_r <= ST_CHECK;
          end
        end
        ST_PUSH: begin
          hvalid_r[hptr_r] <= 1'b1;
          hptr_r <= hptr_r + HP_W'(1);
          if (kin_r + BK_W'(1) >= blk) begin
            kin_r <= '0;
            jout_r <= '0;
          end else kin_r <= kin_r + BK_W'(1);
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_r_r, out_l_r};
  assign out_tlast = out_last_r;

  logic unused_ok;
  assign unused_ok = ^{in_tdata[63:58]};

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> st_r == ST_IDLE) else $error("ready outside idle");
  a_hptr_push: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_PUSH) |=> hptr_r == $past(hptr_r)) else $error("history pointer moved");
  a_kin_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_PUSH) |=> kin_r < blk || kin_r == '0) else $error("block counter range");
endmodule

// File: tb/sv/tb_polyphase_rational_resampler.sv
// Self-checking testbench for the polyphase rational resampler.
`timescale 1ns / 1ps
module tb_polyphase_rational_resampler;
  import prr_pkg::*;

  localparam int DRAIN_CYCLES = 4000;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HIST_DEPTH = 128;
  localparam int COEF_SLOTS = 1024;
  // Coefficients loaded up front; every configuration keeps phase_count * taps within them.
  localparam int COEF_LOADED = 128;

  typedef struct {
    shortint left;
    shortint right;
    bit      last;
  } audio_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic in_tuser = OP_SAMPLE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;

  polyphase_rational_resampler uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Own copy of the resampler state and registers.
  shortint hist_l [HIST_DEPTH];
  shortint hist_r [HIST_DEPTH];
  shortint coefs [COEF_SLOTS];
  int hist_ptr, in_pos, out_pos;
  int r_from, r_to, r_phases, r_taps, r_block;
  bit r_stereo;

  audio_out_t pending_audio[$];
  int errors, samples_sent, coefs_sent, outputs_seen, cycles;
  int send_idle, recv_idle;

  function automatic shortint round_saturate(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return shortint'(r);
  endfunction

  function automatic void predict_sample(shortint sl, shortint sr);
    int fr, to, pc, taps, blk, lim, n, phase, ci, hi;
    longint accl, accr, c;
    audio_out_t o;
    fr = (r_from == 0) ? 1 : r_from;
    to = (r_to == 0) ? 1 : r_to;
    if (fr == to) begin
      o.left = sl;
      o.right = r_stereo ? sr : 16'sd0;
      o.last = 1'b1;
      pending_audio.push_back(o);
      return;
    end
    pc = (r_phases == 0) ? 1 : r_phases;
    taps = (r_taps == 0) ? 1 : (r_taps > HIST_DEPTH ? HIST_DEPTH : r_taps);
    blk = (r_block == 0) ? 1 : (r_block > 1024 ? 1024 : r_block);
    lim = (blk * to) / fr;
    n = 0;
    while (n < RESULTS_MAX && out_pos < lim && out_pos * fr < (in_pos + 1) * to) begin
      phase = ((out_pos * pc * fr) / to) % pc;
      accl = 0;
      accr = 0;
      for (int i = 0; i < taps; i++) begin
        ci = phase + i * pc;
        hi = (hist_ptr + HIST_DEPTH - 1 - i) % HIST_DEPTH;
        c = (ci < COEF_SLOTS) ? longint'(coefs[ci]) : 0;
        accl += c * longint'(hist_l[hi]);
        accr += c * longint'(hist_r[hi]);
      end
      o.left = round_saturate(accl);
      o.right = r_stereo ? round_saturate(accr) : 16'sd0;
      o.last = 1'b0;
      pending_audio.push_back(o);
      n++;
      out_pos++;
    end
    if (n > 0) pending_audio[pending_audio.size()-1].last = 1'b1;
    hist_l[hist_ptr] = sl;
    hist_r[hist_ptr] = sr;
    hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
    in_pos++;
    if (in_pos >= blk) begin
      in_pos = 0;
      out_pos = 0;
    end
  endfunction

  function automatic void note_mismatch(string what, int expv, int actv);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s at output %0d: expected %0d, got %0d", what, outputs_seen,
               expv, actv);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    audio_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_audio.size() == 0) begin
        note_mismatch("unexpected output", 0, 1);
      end else begin
        e = pending_audio.pop_front();
        if (shortint'(out_tdata[15:0]) != e.left)
          note_mismatch("out_left", e.left, shortint'(out_tdata[15:0]));
        if (shortint'(out_tdata[31:16]) != e.right)
          note_mismatch("out_right", e.right, shortint'(out_tdata[31:16]));
        if (out_tlast != e.last) note_mismatch("out_tlast", e.last, out_tlast);
      end
      outputs_seen++;
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d outputs outstanding", pending_audio.size());
      $display("tb_polyphase_rational_resampler: done, errors");
      $finish;
    end
  end

  task automatic send_item(logic op, int idx, shortint cv, shortint sl, shortint sr);
    logic ok;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {6'b0, sr, sl, cv, idx[9:0]};
    forever begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
      if (ok) break;
    end
    if (op == OP_COEF) begin
      coefs[idx] = cv;
      coefs_sent++;
    end else begin
      predict_sample(sl, sr);
      samples_sent++;
    end
  endtask

  task automatic send_sample(shortint sl, shortint sr);
    send_item(OP_SAMPLE, $urandom_range(1023), shortint'($urandom), sl, sr);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_audio.size() != 0) @(posedge clk);
  endtask

  // The block may still be busy on an item that yields nothing, hence the extra wait.
  task automatic quiesce();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(int f, int t, int p, int tp, int b, int s);
    int vals [6];
    vals = '{f, t, p, tp, b, s};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= CFG_DATA_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    r_from = f & 5'h1f;
    r_to = t & 5'h1f;
    r_phases = p & 5'h1f;
    r_taps = tp & 8'hff;
    r_block = b & 11'h7ff;
    r_stereo = s & 1;
  endtask

  task automatic test_passthrough();
    send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, -16'sh0001);
    send_sample(16'sh5555, -16'sh5556);
    send_item(OP_COEF, 1023, 16'sh7fff, 16'sh0, 16'sh0);
    send_item(OP_COEF, 0, -16'sh8000, 16'sh0, 16'sh0);
    quiesce();
    apply_config(0, 0, 0, 0, 0, 0);
    send_sample(16'sh1234, 16'sh4321);
    send_sample(-16'sh8000, 16'sh7fff);
  endtask

  task automatic test_load_coefs();
    for (int i = 0; i < COEF_LOADED; i++)
      send_item(OP_COEF, i, shortint'(int'($urandom_range(4095)) - 2048), 16'sh0, 16'sh0);
  endtask

  task automatic test_extreme_ratios();
    quiesce();
    // Full upsampling with the longest filter, block size beyond the clamp.
    apply_config(1, 16, 1, 255, 2047, 1);
    repeat (3) send_sample(16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7fff);
    quiesce();
    // Strong decimation with one-sample blocks and mono output.
    apply_config(16, 1, 1, 1, 1, 0);
    repeat (3) send_sample(shortint'($urandom), shortint'($urandom));
    quiesce();
    apply_config(16, 1, 3, 4, 20, 1);
    repeat (4) send_sample(shortint'($urandom), shortint'($urandom));
  endtask

  task automatic test_random_segment(int n_items, bit with_pause);
    int tp, b, pick, pc, tp_max;
    shortint sl, sr;
    quiesce();
    pc = $urandom_range(1, 16);
    tp_max = COEF_LOADED / pc;
    tp = ($urandom_range(9) == 0) ? tp_max : $urandom_range(1, (tp_max < 24) ? tp_max : 24);
    b = ($urandom_range(7) == 0) ? $urandom_range(1024, 2047) : $urandom_range(1, 48);
    apply_config($urandom_range(1, 16), $urandom_range(1, 16), pc, tp, b,
                 $urandom_range(1));
    for (int i = 0; i < n_items; i++) begin
      if (with_pause && i == n_items / 2) wait_drained();
      pick = $urandom_range(99);
      sl = shortint'($urandom);
      sr = shortint'($urandom);
      if (pick < 8) begin
        sl = (pick & 1) ? 16'sh7fff : -16'sh8000;
        sr = (pick & 2) ? 16'sh7fff : -16'sh8000;
      end
      if (pick >= 88)
        send_item(OP_COEF, $urandom_range(1023), shortint'($urandom), 16'sh0, 16'sh0);
      else
        send_sample(sl, sr);
    end
  endtask

  task automatic test_random_mode(int s_idle, int r_idle, bit with_pause);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int seg = 0; seg < 4; seg++) test_random_segment(18, with_pause && seg == 2);
  endtask

  initial begin
    for (int i = 0; i < HIST_DEPTH; i++) begin
      hist_l[i] = 0;
      hist_r[i] = 0;
    end
    hist_ptr = 0;
    in_pos = 0;
    out_pos = 0;
    r_from = 1;
    r_to = 1;
    r_phases = 1;
    r_taps = 1;
    r_block = 128;
    r_stereo = 1;
    send_idle = 27;
    recv_idle = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_load_coefs();
    test_extreme_ratios();
    test_random_mode(27, 64, 1'b1);
    test_random_mode(64, 27, 1'b0);
    test_random_mode(0, 0, 1'b0);

    quiesce();
    $display("covered %0d sample transactions and %0d coefficient writes, %0d outputs checked",
             samples_sent, coefs_sent, outputs_seen);
    $display("ratios from pass-through to 16:1 both ways, mono and stereo, up to 128 taps");
    if (errors == 0) begin
      $display("tb_polyphase_rational_resampler: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_polyphase_rational_resampler: done, errors");
    end
    $finish;
  end
endmodule

// File: polyphase_rational_resampler.f
design/prr_pkg.sv
design/prr_mac.sv
design/polyphase_rational_resampler.sv
tb/sv/tb_polyphase_rational_resampler.sv
